// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the 2bpp gray packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define BP2G_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define BP2G_ASSERT_NEVER(label, cond, msg) \
	`BP2G_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/core/bp2g_pkg.sv =====
// Package with types, register indexes and constants of the 2bpp gray packer.
`default_nettype none

package bp2g_pkg;

	// Default frame geometry of the display.
	localparam int FRAME_WIDTH_DEF  = 800;
	localparam int FRAME_HEIGHT_DEF = 480;

	// Configuration port geometry.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 10;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MODE     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_X_OFFSET       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_Y_OFFSET       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_LOW  = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_MID  = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_HIGH = 3'd7;

	// Register values after reset.
	localparam logic       RST_COLOR_MODE     = 1'b1;
	localparam logic [9:0] RST_IMAGE_WIDTH    = 10'd800;
	localparam logic [8:0] RST_IMAGE_HEIGHT   = 9'd480;
	localparam logic [9:0] RST_X_OFFSET       = 10'd0;
	localparam logic [8:0] RST_Y_OFFSET       = 9'd0;
	localparam logic [7:0] RST_THRESHOLD_LOW  = 8'd64;
	localparam logic [7:0] RST_THRESHOLD_MID  = 8'd128;
	localparam logic [7:0] RST_THRESHOLD_HIGH = 8'd212;

	// Divide by three of a sum below 1536: (x * 683) >> 11.
	localparam logic [9:0] DIV3_RECIP = 10'd683;
	localparam int         DIV3_SHIFT = 11;

	// Bytes of one BGR triple, counted from zero.
	localparam logic [1:0] LAST_BGR_BYTE = 2'd2;

	// Output field widths.
	localparam int ADDR_W  = 17;
	localparam int LANE_W  = 2;
	localparam int LEVEL_W = 2;

	typedef struct packed {
		logic       color_mode;
		logic [9:0] image_width;
		logic [8:0] image_height;
		logic [9:0] x_offset;
		logic [8:0] y_offset;
		logic [7:0] threshold_low;
		logic [7:0] threshold_mid;
		logic [7:0] threshold_high;
	} cfg_t;

	// One framebuffer write as seen by the result stage.
	typedef struct packed {
		logic              emit;
		logic [ADDR_W-1:0] byte_address;
		logic [LANE_W-1:0] pixel_lane;
		logic              last_pixel;
	} pix_t;

endpackage

`default_nettype wire

// ===== rtl/core/bp2g_level.sv =====
// Gray level of a finished pixel: BGR average with thresholds, or top bits of a gray byte.
`default_nettype none

module bp2g_level
	import bp2g_pkg::*;
(
	input  cfg_t               cfg,
	input  logic [7:0]         data_byte,
	input  logic [9:0]         psum,
	output logic [LEVEL_W-1:0] gray_level
);

	logic [9:0]  sum;
	logic [19:0] prod;
	logic [7:0]  gray;

	// The sum of three bytes stays below 766, so the reciprocal is exact here.
	assign sum  = psum + 10'(data_byte);
	assign prod = 20'(sum) * 20'(DIV3_RECIP);
	assign gray = prod[DIV3_SHIFT +: 8];

	always_comb begin
		if (!cfg.color_mode) begin
			gray_level = data_byte[7:6];
		end else if (gray < cfg.threshold_low) begin
			gray_level = 2'd0;
		end else if (gray < cfg.threshold_mid) begin
			gray_level = 2'd1;
		end else if (gray < cfg.threshold_high) begin
			gray_level = 2'd2;
		end else begin
			gray_level = 2'd3;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bp2g_raster.sv =====
// Raster tracking of the BMP byte stream: triples, padding, rows and frame address.
`default_nettype none

module bp2g_raster
	import bp2g_pkg::*;
#(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       restart,
	input  logic [8:0] restart_height,
	input  logic       step,
	input  cfg_t       cfg,
	input  logic [7:0] data_byte,
	output logic [9:0] psum,
	output pix_t       pix
);

	`include "assert_macros.svh"

	localparam int MUL_W = 10 + $clog2(FRAME_WIDTH + 1);
	localparam int IDX_W = ADDR_W + LANE_W;

	logic [9:0] col_q;
	logic [8:0] row_q;
	logic [1:0] bip_q;
	logic [1:0] pad_q;
	logic [9:0] psum_q;
	logic       fin_q;

	logic [9:0]       eff_w;
	logic             row_end_col;
	logic [1:0]       pad_sel;
	logic             pix_done;
	logic [10:0]      fx;
	logic [9:0]       fy;
	logic             in_frame;
	logic [MUL_W-1:0] row_base;
	logic [IDX_W-1:0] idx;

	assign eff_w       = (cfg.image_width == 10'd0) ? 10'd1 : cfg.image_width;
	assign row_end_col = (11'(col_q) + 11'd1) >= 11'(eff_w);
	// Row bytes pad to a multiple of four: 3w bytes need w mod 4, w bytes need -w mod 4.
	assign pad_sel     = cfg.color_mode ? eff_w[1:0] : (2'd0 - eff_w[1:0]);
	assign pix_done    = !fin_q && (pad_q == 2'd0) &&
		(!cfg.color_mode || (bip_q == LAST_BGR_BYTE));

	assign fx       = 11'(cfg.x_offset) + 11'(col_q);
	assign fy       = 10'(cfg.y_offset) + 10'(row_q);
	assign in_frame = (32'(fx) < 32'(FRAME_WIDTH)) && (32'(fy) < 32'(FRAME_HEIGHT));
	assign row_base = MUL_W'(fy) * MUL_W'(FRAME_WIDTH);
	assign idx      = IDX_W'(row_base) + IDX_W'(fx);

	assign psum             = psum_q;
	assign pix.emit         = pix_done && in_frame;
	assign pix.byte_address = idx[IDX_W-1:LANE_W];
	assign pix.pixel_lane   = idx[LANE_W-1:0];
	assign pix.last_pixel   = (row_q == 9'd0) && row_end_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= RST_IMAGE_HEIGHT - 9'd1;
			bip_q  <= '0;
			pad_q  <= '0;
			psum_q <= '0;
			fin_q  <= 1'b0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= restart_height - 9'd1;
			bip_q  <= '0;
			pad_q  <= '0;
			psum_q <= '0;
			fin_q  <= 1'b0;
		end else if (step && !fin_q) begin
			if (pad_q != 2'd0) begin
				pad_q <= pad_q - 2'd1;
				if (pad_q == 2'd1) begin
					col_q <= '0;
					if (row_q == 9'd0) begin
						fin_q <= 1'b1;
					end else begin
						row_q <= row_q - 9'd1;
					end
				end
			end else if (cfg.color_mode && (bip_q != LAST_BGR_BYTE)) begin
				psum_q <= psum_q + 10'(data_byte);
				bip_q  <= bip_q + 2'd1;
			end else begin
				bip_q  <= '0;
				psum_q <= '0;
				col_q  <= col_q + 10'd1;
				if (row_end_col) begin
					if (pad_sel != 2'd0) begin
						pad_q <= pad_sel;
					end else begin
						col_q <= '0;
						if (row_q == 9'd0) begin
							fin_q <= 1'b1;
						end else begin
							row_q <= row_q - 9'd1;
						end
					end
				end
			end
		end
	end

	// While row padding is skipped the column count sits one past the last pixel.
	`BP2G_ASSERT(a_col_in_row, (pad_q == 2'd0) |-> (11'(col_q) < 11'(eff_w)), "column past row end")
	`BP2G_ASSERT_NEVER(a_bip_range, bip_q == 2'd3, "byte count of a triple ran past three")
	`BP2G_ASSERT(a_pad_clean, (pad_q != 2'd0) |-> (bip_q == 2'd0 && !fin_q), "padding during a triple")

endmodule

`default_nettype wire

// ===== rtl/core/bmp_pixels_to_2bpp_gray_unit.sv =====
// Top level of the BMP pixel to 2bpp grayscale framebuffer write converter.
//
// Usage: the pixel-data bytes of a BMP image (after its header) enter one per
// beat on the s_axis channel. Rows arrive bottom-up and padded to four bytes.
// Every finished pixel that lands inside the frame leaves as one beat on the
// m_axis channel: a framebuffer byte address, a 2-bit lane and a 2-bit gray
// level, with tlast marking the final pixel of the image. Padding bytes, the
// first two bytes of a BGR triple and pixels outside the frame give no beat.
// An accepted byte waits in the byte register, is worked on by the raster
// logic as it leaves that register, and its result shows on m_axis from the
// result register; one byte register and one result register sit on the path.
// Throughput: one byte per cycle while the receiver keeps up, so one pixel per
// cycle in 8-bit mode and one pixel per BGR triple in 24-bit mode; the raster
// counters advance on each byte. When the receiver stalls, the result register
// holds and the next byte waits in the byte register, even one that gives no
// beat; s_axis_tready stays high only while that register is empty, so at most
// one more byte is taken before it drops. Reset loads the register defaults
// and starts a new image at the bottom row. Any configuration write also
// restarts the image; writes belong to idle periods between images.
`default_nettype none

module bmp_pixels_to_2bpp_gray_unit
	import bp2g_pkg::*;
#(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration write port.
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// Input byte stream.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // [7:0] data_byte
	// Framebuffer write stream.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [23:0]            m_axis_tdata,  // [16:0] byte_address, [18:17] pixel_lane,
	                                              // [20:19] gray_level, [23:21] zero
	output logic                   m_axis_tlast   // last_pixel
);

	`include "assert_macros.svh"

	cfg_t cfg_q;
	logic [8:0] restart_height;

	logic       valid_s1;
	logic [7:0] byte_s1;

	logic               valid_s2;
	logic [ADDR_W-1:0]  addr_s2;
	logic [LANE_W-1:0]  lane_s2;
	logic [LEVEL_W-1:0] level_s2;
	logic               last_s2;

	logic               can_load;
	logic               step;
	logic [9:0]         psum;
	pix_t               pix;
	logic [LEVEL_W-1:0] gray_level;

	// The result register can take a new beat when empty or being drained.
	assign can_load      = !valid_s2 || m_axis_tready;
	assign step          = valid_s1 && can_load;
	assign s_axis_tready = !valid_s1 || can_load;

	// Restart uses the height that the write in this cycle leaves behind.
	assign restart_height = (cfg_index == CFG_IMAGE_HEIGHT) ? cfg_data[8:0] : cfg_q.image_height;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_mode     <= RST_COLOR_MODE;
			cfg_q.image_width    <= RST_IMAGE_WIDTH;
			cfg_q.image_height   <= RST_IMAGE_HEIGHT;
			cfg_q.x_offset       <= RST_X_OFFSET;
			cfg_q.y_offset       <= RST_Y_OFFSET;
			cfg_q.threshold_low  <= RST_THRESHOLD_LOW;
			cfg_q.threshold_mid  <= RST_THRESHOLD_MID;
			cfg_q.threshold_high <= RST_THRESHOLD_HIGH;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLOR_MODE:     cfg_q.color_mode     <= cfg_data[0];
				CFG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_data[9:0];
				CFG_IMAGE_HEIGHT:   cfg_q.image_height   <= cfg_data[8:0];
				CFG_X_OFFSET:       cfg_q.x_offset       <= cfg_data[9:0];
				CFG_Y_OFFSET:       cfg_q.y_offset       <= cfg_data[8:0];
				CFG_THRESHOLD_LOW:  cfg_q.threshold_low  <= cfg_data[7:0];
				CFG_THRESHOLD_MID:  cfg_q.threshold_mid  <= cfg_data[7:0];
				CFG_THRESHOLD_HIGH: cfg_q.threshold_high <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Byte register in front of the raster logic.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	bp2g_raster #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_raster (
		.clk            (clk),
		.arst_n         (arst_n),
		.restart        (cfg_we),
		.restart_height (restart_height),
		.step           (step),
		.cfg            (cfg_q),
		.data_byte      (byte_s1),
		.psum           (psum),
		.pix            (pix)
	);

	bp2g_level u_level (
		.cfg        (cfg_q),
		.data_byte  (byte_s1),
		.psum       (psum),
		.gray_level (gray_level)
	);

	// Result register; a byte that finishes no visible pixel leaves it empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= step && pix.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && pix.emit) begin
			addr_s2  <= pix.byte_address;
			lane_s2  <= pix.pixel_lane;
			level_s2 <= gray_level;
			last_s2  <= pix.last_pixel;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, level_s2, lane_s2, addr_s2};
	assign m_axis_tlast  = last_s2;

	`BP2G_ASSERT(a_out_from_s1, $rose(valid_s2) |-> $past(valid_s1), "result without a byte")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the BMP pixel to 2bpp grayscale framebuffer write converter.
`timescale 1ns / 1ps

module tb_top;
	import bp2g_pkg::*;

	localparam int FW = FRAME_WIDTH_DEF;
	localparam int FH = FRAME_HEIGHT_DEF;

	// Stimulus volume and timing knobs.
	localparam int RANDOM_ITEMS     = 1800;
	localparam int SETTLE_CYCLES    = 8;    // lets the byte and result registers of the block drain
	localparam int LONG_HOLD_CYCLES = 400;
	// The quietest correct stretch is the long receiver hold plus one short stall, so
	// reaching QUIET_LIMIT without any beat on either side can only mean a hang.
	localparam int QUIET_LIMIT      = 2000;

	// Bit positions of the fields inside m_axis_tdata.
	localparam int LANE_LSB  = ADDR_W;
	localparam int LEVEL_LSB = ADDR_W + LANE_W;
	localparam int PAD_LSB   = ADDR_W + LANE_W + LEVEL_W;

	typedef enum logic [1:0] {
		LVL_BLACK,
		LVL_DARK,
		LVL_LIGHT,
		LVL_WHITE
	} gray_level_t;

	// One framebuffer write as it should leave the block.
	typedef struct packed {
		logic [ADDR_W-1:0] byte_address;
		logic [LANE_W-1:0] pixel_lane;
		gray_level_t       gray_level;
		logic              last_pixel;
	} fb_write_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [23:0]            m_tdata;
	logic                   m_tlast;

	// Bytes waiting to be offered, and framebuffer writes waiting to be seen.
	logic [7:0] pixel_bytes[$];
	fb_write_t  fb_expected[$];

	// Shadow copy of the registers and of the raster position of the block.
	cfg_t       shadow;
	logic [9:0] col_cnt;
	logic [8:0] row_cnt;
	logic [1:0] bgr_idx;
	logic [1:0] pad_left;
	logic [9:0] bg_sum;
	logic       img_done;

	// Handshake pacing state.
	logic calm          = 1'b0;   // no idling on either side once set
	int   send_gap      = 0;
	int   recv_stall    = 0;
	int   long_hold     = 0;
	int   hold_requests = 0;
	int   holds_served  = 0;
	int   quiet_cycles  = 0;
	int   fail_count    = 0;

	bmp_pixels_to_2bpp_gray_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Any register write, and reset, starts a new image at the bottom row.
	function automatic void restart_raster();
		col_cnt  = '0;
		row_cnt  = shadow.image_height - 1'b1;
		bgr_idx  = '0;
		pad_left = '0;
		bg_sum   = '0;
		img_done = 1'b0;
	endfunction

	// Rows count down; the image is done after row zero.
	function automatic void finish_row();
		col_cnt = '0;
		if (row_cnt == 0)
			img_done = 1'b1;
		else
			row_cnt = row_cnt - 1'b1;
	endfunction

	// Advances the shadow raster by one accepted byte and queues the write it causes.
	function automatic void predict_byte(input logic [7:0] b);
		int unsigned w, pad, gray, col, row, fx, fy, idx;
		gray_level_t level;
		fb_write_t   wr;
		w = (shadow.image_width == 0) ? 1 : shadow.image_width;
		if (img_done)
			return;
		// Row padding only counts down.
		if (pad_left != 0) begin
			pad_left = pad_left - 1'b1;
			if (pad_left == 0)
				finish_row();
			return;
		end
		if (shadow.color_mode) begin
			// Blue and green just accumulate; red completes the pixel.
			if (bgr_idx < LAST_BGR_BYTE) begin
				bg_sum  = bg_sum + b;
				bgr_idx = bgr_idx + 1'b1;
				return;
			end
			gray = (bg_sum + b) / 3;
			// The compares go in order, so unordered thresholds let the first match win.
			if (gray < shadow.threshold_low)
				level = LVL_BLACK;
			else if (gray < shadow.threshold_mid)
				level = LVL_DARK;
			else if (gray < shadow.threshold_high)
				level = LVL_LIGHT;
			else
				level = LVL_WHITE;
			bgr_idx = '0;
			bg_sum  = '0;
			pad     = (4 - ((w * 3) & 3)) & 3;
		end else begin
			level = gray_level_t'(b[7:6]);
			pad   = (4 - (w & 3)) & 3;
		end
		col = col_cnt;
		row = row_cnt;
		wr.last_pixel = (row == 0) && (col + 1 >= w);
		col_cnt = col_cnt + 1'b1;
		if (col + 1 >= w) begin
			if (pad != 0)
				pad_left = pad[1:0];
			else
				finish_row();
		end
		// Pixels off the frame are dropped, including a final one with its tlast.
		fx = shadow.x_offset + col;
		fy = shadow.y_offset + row;
		if (fx >= FW || fy >= FH)
			return;
		idx = fy * FW + fx;
		wr.byte_address = idx[ADDR_W+1:2];
		wr.pixel_lane   = idx[1:0];
		wr.gray_level   = level;
		fb_expected.push_back(wr);
	endfunction

	// Number of bytes in a complete image under the current registers.
	function automatic int unsigned image_bytes();
		int unsigned w, row_bytes, rows;
		w         = (shadow.image_width == 0) ? 1 : shadow.image_width;
		row_bytes = shadow.color_mode ? w * 3 : w;
		row_bytes = row_bytes + ((4 - (row_bytes & 3)) & 3);
		rows      = (shadow.image_height == 0) ? 512 : shadow.image_height;
		return row_bytes * rows;
	endfunction

	// Random pixel byte, leaning on the extremes so that every level shows up.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_index,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= reg_index;
		cfg_data  <= value;
		case (reg_index)
			CFG_COLOR_MODE:     shadow.color_mode     = value[0];
			CFG_IMAGE_WIDTH:    shadow.image_width    = value[9:0];
			CFG_IMAGE_HEIGHT:   shadow.image_height   = value[8:0];
			CFG_X_OFFSET:       shadow.x_offset       = value[9:0];
			CFG_Y_OFFSET:       shadow.y_offset       = value[8:0];
			CFG_THRESHOLD_LOW:  shadow.threshold_low  = value[7:0];
			CFG_THRESHOLD_MID:  shadow.threshold_mid  = value[7:0];
			CFG_THRESHOLD_HIGH: shadow.threshold_high = value[7:0];
			default: ;
		endcase
		restart_raster();
	endtask

	// Writes every register. With junk set, the unused upper data bits carry noise
	// that the block has to ignore.
	task automatic configure(input logic mode, input logic [9:0] w, input logic [8:0] h,
			input logic [9:0] xo, input logic [8:0] yo, input logic [7:0] tl,
			input logic [7:0] tm, input logic [7:0] th, input logic junk_on);
		logic [9:0] junk;
		junk = junk_on ? 10'($urandom) : '0;
		write_reg(CFG_COLOR_MODE, {junk[9:1], mode});
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, {junk[9], h});
		write_reg(CFG_X_OFFSET, xo);
		write_reg(CFG_Y_OFFSET, {junk[9], yo});
		write_reg(CFG_THRESHOLD_LOW, {junk[9:8], tl});
		write_reg(CFG_THRESHOLD_MID, {junk[9:8], tm});
		write_reg(CFG_THRESHOLD_HIGH, {junk[9:8], th});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Queues a directed byte sequence, first byte in the lowest bits.
	task automatic queue_bytes(input logic [127:0] packed_bytes, input int count);
		for (int i = 0; i < count; i++)
			pixel_bytes.push_back(packed_bytes[8*i +: 8]);
	endtask

	// Waits until every byte went in and every write came out, then lets the
	// block finish any bytes that give no write.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (!(pixel_bytes.size() == 0 && !s_tvalid && fb_expected.size() == 0));
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sender: feeds the byte queue to s_axis, with random idle bursts between beats.
	// The prediction runs on every accepted beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_byte(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pixel_bytes.size() > 0) begin
					s_tdata  <= pixel_bytes.pop_front();
					s_tvalid <= 1'b1;
					if (!calm && $urandom_range(0, 15) == 0)
						send_gap = $urandom_range(1, 18);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stall bursts, plus a long hold-off on request during which the
	// sender keeps offering, so the block fills up and drops s_axis_tready.
	always @(posedge clk) begin
		if (arst_n) begin
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				long_hold    = LONG_HOLD_CYCLES;
			end
			if (long_hold > 0) begin
				long_hold--;
				m_tready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 11) == 0)
					recv_stall = $urandom_range(1, 18);
			end
		end
	end

	// Checker: every accepted write beat against the oldest predicted write.
	always @(posedge clk) begin
		fb_write_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (fb_expected.size() == 0) begin
				$error("framebuffer write with nothing expected: tdata %h tlast %b",
					m_tdata, m_tlast);
				fail_count++;
			end else begin
				want = fb_expected.pop_front();
				if (m_tdata[ADDR_W-1:0] !== want.byte_address) begin
					$error("byte_address: expected %0d, actual %0d",
						want.byte_address, m_tdata[ADDR_W-1:0]);
					fail_count++;
				end
				if (m_tdata[LEVEL_LSB-1:LANE_LSB] !== want.pixel_lane) begin
					$error("pixel_lane: expected %0d, actual %0d",
						want.pixel_lane, m_tdata[LEVEL_LSB-1:LANE_LSB]);
					fail_count++;
				end
				if (m_tdata[PAD_LSB-1:LEVEL_LSB] !== want.gray_level) begin
					$error("gray_level: expected %0d, actual %0d",
						want.gray_level, m_tdata[PAD_LSB-1:LEVEL_LSB]);
					fail_count++;
				end
				if (m_tdata[23:PAD_LSB] !== '0) begin
					$error("tdata fill bits: expected 0, actual %0d", m_tdata[23:PAD_LSB]);
					fail_count++;
				end
				if (m_tlast !== want.last_pixel) begin
					$error("last_pixel: expected %0d, actual %0d", want.last_pixel, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no beat on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned random_items, n, phase;
		logic       mode, broken;
		logic [9:0] w, xo;
		logic [8:0] h, yo;
		logic [7:0] t0, t1, t2, tmp;

		shadow = '{
			color_mode:     RST_COLOR_MODE,
			image_width:    RST_IMAGE_WIDTH,
			image_height:   RST_IMAGE_HEIGHT,
			x_offset:       RST_X_OFFSET,
			y_offset:       RST_Y_OFFSET,
			threshold_low:  RST_THRESHOLD_LOW,
			threshold_mid:  RST_THRESHOLD_MID,
			threshold_high: RST_THRESHOLD_HIGH
		};
		restart_raster();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: a black and a white pixel at the start of the bottom row,
		// which lands on the last frame row.
		queue_bytes(48'hFFFFFF000000, 6);
		wait_idle();

		// One pixel column at the far frame corner: the first row received gives the
		// highest byte address, the last one carries tlast. A gray of exactly the
		// mid threshold must give light gray. Padding bytes are nonzero on purpose.
		configure(1'b1, 10'd1, 9'd2, 10'(FW - 1), 9'(FH - 2), RST_THRESHOLD_LOW,
			RST_THRESHOLD_MID, RST_THRESHOLD_HIGH, 1'b0);
		queue_bytes(64'hFF81807F5AFFFFFF, 8);
		wait_idle();

		// 8-bit mode with one pad byte per row, all four levels, junk in the upper
		// data bits, and two trailing bytes that arrive after the image is done.
		configure(1'b0, 10'd3, 9'd2, 10'd0, 9'd0, 8'd200, 8'd100, 8'd50, 1'b1);
		queue_bytes(80'h00FF557FFFC0AA804000, 10);
		wait_idle();

		// Random images. A few early phases are forced onto special cases: zero width,
		// zero height (512 rows, cut short), a full-width row, the long receiver
		// hold-off and the tallest height. Most phases send whole images.
		random_items = 0;
		phase        = 0;
		while (random_items < RANDOM_ITEMS) begin
			mode   = 1'($urandom_range(0, 1));
			w      = 10'($urandom_range(1, 6));
			h      = 9'($urandom_range(1, 4));
			broken = 1'b0;
			if ($urandom_range(0, 7) == 0)
				w = 10'($urandom_range(7, 40));
			if ($urandom_range(0, 9) == 0) begin
				h      = 9'($urandom_range(5, 511));
				broken = 1'b1;
			end

			case ($urandom_range(0, 7))
				0, 1:    xo = 0;
				2, 3:    xo = 10'($urandom_range(FW - 8, FW - 1));
				4, 5, 6: xo = 10'($urandom_range(0, FW - 1));
				default: xo = 10'($urandom_range(FW, 1023));
			endcase
			case ($urandom_range(0, 7))
				0, 1:    yo = 0;
				2, 3:    yo = 9'($urandom_range(FH - 8, FH - 1));
				4, 5, 6: yo = 9'($urandom_range(0, FH - 1));
				default: yo = 9'($urandom_range(FH, 511));
			endcase

			t0 = 8'($urandom);
			t1 = 8'($urandom);
			t2 = 8'($urandom);
			case ($urandom_range(0, 3))
				0: begin
					if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
					if (t1 > t2) begin tmp = t1; t1 = t2; t2 = tmp; end
					if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
				end
				1: ;  // left unordered
				2: {t0, t1, t2} = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
				default: begin
					t0 = RST_THRESHOLD_LOW;
					t1 = RST_THRESHOLD_MID;
					t2 = RST_THRESHOLD_HIGH;
				end
			endcase

			case (phase)
				0: w = 0;
				1: begin
					w      = 1;
					h      = 0;
					yo     = 0;
					broken = 1'b0;
				end
				2: begin
					mode   = 1'b0;
					h      = 1;
					broken = 1'b0;
					case ($urandom_range(0, 2))
						0:       w = 10'(FW);
						1:       w = 10'd1023;
						default: w = 10'($urandom_range(700, 1023));
					endcase
				end
				3: begin
					mode   = 1'b0;
					w      = 8;
					h      = 4;
					xo     = 0;
					yo     = 0;
					broken = 1'b0;
				end
				4: begin
					h      = 9'd511;
					broken = 1'b1;
				end
				default: ;
			endcase

			configure(mode, w, h, xo, yo, t0, t1, t2, 1'($urandom_range(0, 3) == 0));
			n = image_bytes();
			if (phase == 1)
				n = 200;  // rows 511 down to 462: rows 480 and up fall off the frame
			else if (broken)
				n = $urandom_range(1, (n < 120) ? n : 120);
			if (phase == 3)
				hold_requests++;
			repeat (n) pixel_bytes.push_back(pick_byte());
			random_items += n;
			// Bytes after a complete image are ignored and do not count.
			if (!broken && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 4)) pixel_bytes.push_back(pick_byte());
			if (random_items >= RANDOM_ITEMS * 85 / 100)
				calm = 1'b1;
			wait_idle();
			phase++;
		end

		if (fail_count == 0 && fb_expected.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bp2g_pkg.sv
rtl/core/bp2g_level.sv
rtl/core/bp2g_raster.sv
rtl/core/bmp_pixels_to_2bpp_gray_unit.sv
verif/tb_top.sv
